// File: design/ftb42_pkg.sv
// Shared types, constants and the character classifier for the base-42 packer.
// No dependencies.
package ftb42_pkg;

   localparam int CNT_W      = 4;   // holds kept count 0..13
   localparam int SYM_W      = 6;   // alphabet index 0..41
   localparam int ACC_W      = 71;
   localparam int HIGH_W     = 7;
   localparam int LOW_W      = 64;
   localparam int CHAR_W     = 8;
   localparam int DEF_MAX_CHARS = 13;
   localparam int FIFO_DEPTH = 2;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   // one classified character handed from front to back
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             do_fold;
      logic             last;
      logic [CNT_W-1:0] pad;
   } cmd_type;

   // index in " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-./?", 0 when not found
   function automatic logic [SYM_W-1:0] symbol_index(input logic [CHAR_W-1:0] ch);
      logic [SYM_W-1:0] idx;
      idx = '0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         idx = SYM_W'(ch - 8'h30 + 8'd1);
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         idx = SYM_W'(ch - 8'h41 + 8'd11);
      end else begin
         case (ch)
            8'h2B:   idx = 6'd37;
            8'h2D:   idx = 6'd38;
            8'h2E:   idx = 6'd39;
            8'h2F:   idx = 6'd40;
            8'h3F:   idx = 6'd41;
            default: idx = '0;
         endcase
      end
      return idx;
   endfunction

endpackage

// File: design/free_text_base42_packer.sv
// Free-text base-42 packer: top level joining front end, command queue and back end.
// Depends on ftb42_pkg, ftb42_front, ftb42_fifo, ftb42_back.
//
// Packs a free-text message, one ASCII character per beat, into the 71-bit
// base-42 value of a 77-bit free-text message (append six zero bits for the
// full message). Leading spaces are dropped; the first MAX_CHARS kept
// characters are mapped into the alphabet " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-./?"
// (anything else counts as a space) and folded in as acc = acc*42 + index;
// later characters are ignored. The beat with req_last_char set closes the
// message: missing positions are padded with zeros, one result beat comes out
// on rsp_value_high/rsp_value_low, and the block starts over for the next
// message. Timing: the front end takes one character per cycle, while req_full
// is low, into a two-entry command queue, and the back end's multiply-by-42 adder
// retires one character per cycle while it is idle; the closing character is
// followed by zero-padding folds for the missing positions and then a load of
// the result register. req_full rises only while the queue is full, i.e. while
// the back end is padding, loading the result register or waiting for rsp_pop.
module free_text_base42_packer import ftb42_pkg::*; #(
   parameter int MAX_CHARS = DEF_MAX_CHARS   // 1..13
) (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_push,
   output logic              req_full,
   input  logic [CHAR_W-1:0] req_character,
   input  logic              req_last_char,
   // result channel
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [HIGH_W-1:0] rsp_value_high,
   output logic [LOW_W-1:0]  rsp_value_low
);

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    req_accept;
   logic    cmd_empty;
   logic    cmd_pop;

   // a beat is taken whenever the queue has room
   assign req_accept = req_push && !req_full;

   ftb42_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .character (req_character),
      .last_char (req_last_char),
      .cmd       (front_cmd)
   );

   ftb42_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept),
      .wr_data (front_cmd),
      .full    (req_full),
      .rd_en   (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (back_cmd)
   );

   ftb42_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd            (back_cmd),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_value_high (rsp_value_high),
      .rsp_value_low  (rsp_value_low)
   );

endmodule

// File: design/ftb42_front.sv
// Front end: skips leading spaces, counts kept characters, classifies each
// character into a fold command. Depends on ftb42_pkg.
module ftb42_front import ftb42_pkg::*; #(
   parameter int MAX_CHARS = DEF_MAX_CHARS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CHAR_W-1:0] character,
   input  logic              last_char,
   output cmd_type           cmd
);

   logic             started_ff, started_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic             started_now;
   logic             fold_now;
   logic [CNT_W-1:0] kept_now;

   always_comb begin
      started_now = started_ff | (character != SPACE_CHAR);
      fold_now    = started_now && (kept_ff < CNT_W'(MAX_CHARS));
      kept_now    = kept_ff + CNT_W'(fold_now);

      cmd.sym     = symbol_index(character);
      cmd.do_fold = fold_now;
      cmd.last    = last_char;
      cmd.pad     = CNT_W'(MAX_CHARS) - kept_now;

      started_in = started_ff;
      kept_in    = kept_ff;
      if (accept) begin
         if (last_char) begin
            started_in = 1'b0;
            kept_in    = '0;
         end else begin
            started_in = started_now;
            kept_in    = kept_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         kept_ff    <= '0;
      end else begin
         started_ff <= started_in;
         kept_ff    <= kept_in;
      end
   end

endmodule

// File: design/ftb42_fifo.sv
// Short command queue between front and back.
// Depends on ftb42_pkg.
module ftb42_fifo import ftb42_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    empty,
   output cmd_type rd_data
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_QW'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/ftb42_back.sv
// Back end: 71-bit base-42 accumulator, zero padding sequencer and result
// register. Depends on ftb42_pkg.
module ftb42_back import ftb42_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [HIGH_W-1:0] rsp_value_high,
   output logic [LOW_W-1:0]  rsp_value_low
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PAD  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // acc*42 + idx = acc<<5 + acc<<3 + acc<<1 + idx, kept to 71 bits
   function automatic logic [ACC_W-1:0] fold42(input logic [ACC_W-1:0] acc,
                                               input logic [SYM_W-1:0] idx);
      return (acc << 5) + (acc << 3) + (acc << 1) + ACC_W'(idx);
   endfunction

   state_type         state_ff, state_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  pad_ff, pad_in;
   logic              out_valid_ff, out_valid_in;
   logic [ACC_W-1:0]  out_ff, out_in;
   logic              load_out;
   logic              take_out;

   assign take_out       = rsp_pop && out_valid_ff;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_value_high = out_ff[ACC_W-1:LOW_W];
   assign rsp_value_low  = out_ff[LOW_W-1:0];

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      pad_in   = pad_ff;
      out_in   = out_ff;
      cmd_pop  = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.do_fold) begin
                  acc_in = fold42(acc_ff, cmd.sym);
               end
               if (cmd.last) begin
                  pad_in   = cmd.pad;
                  state_in = (cmd.pad != '0) ? ST_PAD : ST_EMIT;
               end
            end
         end
         ST_PAD: begin
            acc_in = fold42(acc_ff, '0);
            pad_in = pad_ff - CNT_W'(1);
            if (pad_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               load_out = 1'b1;
               out_in   = acc_ff;
               acc_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load_out ? 1'b1 : (take_out ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pad_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pad_ff       <= pad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
